>>> rtl/hdlc_frame_encoder_crc_core_macros.svh
// assertion macros for the framer rtl, used by the byte sequencer
`ifndef HDLC_FRAME_ENCODER_CRC_CORE_MACROS_SVH
`define HDLC_FRAME_ENCODER_CRC_CORE_MACROS_SVH

// condition holds in the same cycle
`define HFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define HFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hfe_pkg.sv
// types, constants and check functions of the hdlc framer
package hfe_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_MASK  = 8'h20;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_ADDR_W = 3;
    localparam logic REG_CHECK_MODE = 1'b0;

    localparam logic MODE_SUM = 1'b0;
    localparam logic MODE_CRC = 1'b1;

    typedef struct packed {
        logic        open;
        logic [7:0]  data;
        logic        last;
        logic [15:0] crc;
        logic [31:0] sum;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPEN,
        ST_DATA,
        ST_HI,
        ST_LO,
        ST_CLOSE
    } back_state_t;

    // crc-16/xmodem over one byte, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // end-around carry fold and invert
    function automatic logic [15:0] fold_sum(input logic [31:0] s);
        logic [16:0] s1;
        logic [15:0] s2;
        s1 = {1'b0, s[31:16]} + {1'b0, s[15:0]};
        s2 = s1[15:0] + {15'd0, s1[16]};
        return ~s2;
    endfunction

endpackage

>>> rtl/hfe_front.sv
// front end: takes payload words and keeps both running checks
module hfe_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // data_byte
    input  logic            s_tlast,   // last_byte
    input  logic            q_full,
    output logic            q_push,
    output hfe_pkg::entry_t q_entry
);
    import hfe_pkg::*;

    logic        in_frame_reg, in_frame_next;
    logic        odd_reg, odd_next;
    logic [15:0] crc_reg, crc_next;
    logic [31:0] sum_reg, sum_next;
    logic [15:0] crc_upd;
    logic [31:0] sum_upd;
    logic [31:0] addend;
    logic        accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // a byte at an even position is the high half, unless it closes the frame
    assign addend  = (odd_reg || s_tlast) ? {24'd0, s_tdata} : {16'd0, s_tdata, 8'd0};
    assign crc_upd = crc_byte(crc_reg, s_tdata);
    assign sum_upd = sum_reg + addend;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        odd_next      = odd_reg;
        crc_next      = crc_reg;
        sum_next      = sum_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                in_frame_next = 1'b0;
                odd_next      = 1'b0;
                crc_next      = 16'd0;
                sum_next      = 32'd0;
            end
            else
            begin
                in_frame_next = 1'b1;
                odd_next      = !odd_reg;
                crc_next      = crc_upd;
                sum_next      = sum_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            odd_reg      <= 1'b0;
            crc_reg      <= 16'd0;
            sum_reg      <= 32'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            odd_reg      <= odd_next;
            crc_reg      <= crc_next;
            sum_reg      <= sum_next;
        end
    end

    assign q_push       = accept;
    assign q_entry.open = !in_frame_reg;
    assign q_entry.data = s_tdata;
    assign q_entry.last = s_tlast;
    assign q_entry.crc  = crc_upd;
    assign q_entry.sum  = sum_upd;

endmodule

>>> rtl/hfe_queue.sv
// short queue between front end and byte sequencer
module hfe_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hfe_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output hfe_pkg::entry_t head
);
    import hfe_pkg::*;

    entry_t                 slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> rtl/hfe_back.sv
// byte sequencer: flags, stuffing and check bytes into the output register
`include "hdlc_frame_encoder_crc_core_macros.svh"

module hfe_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            check_mode,
    input  logic            q_empty,
    input  hfe_pkg::entry_t q_head,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // end_of_run
    output logic            m_tuser    // end_of_frame
);
    import hfe_pkg::*;

    back_state_t state_reg, state_next;
    logic        esc_pending_reg, esc_pending_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic [15:0] check_reg, check_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;
    logic        out_eof_reg, out_eof_next;

    logic [7:0]  cur_val;
    logic        stuffed;
    logic        needs_esc;
    logic        can_emit;
    logic        step_done;
    logic        entry_done;
    logic        load;
    logic [7:0]  emit_byte;

    assign can_emit  = (state_reg != ST_IDLE) && (!out_valid_reg || m_tready);
    assign needs_esc = (cur_val == FLAG_BYTE) || (cur_val == ESC_BYTE);

    always_comb
    begin
        cur_val          = 8'd0;
        stuffed          = 1'b0;
        state_next       = state_reg;
        esc_pending_next = esc_pending_reg;
        byte_next        = byte_reg;
        last_next        = last_reg;
        check_next       = check_reg;
        entry_done       = 1'b0;
        load             = 1'b0;

        unique case (state_reg)
            ST_DATA:
            begin
                cur_val = byte_reg;
                stuffed = 1'b1;
            end
            ST_HI:
            begin
                cur_val = check_reg[15:8];
                stuffed = 1'b1;
            end
            ST_LO:
            begin
                cur_val = check_reg[7:0];
                stuffed = 1'b1;
            end
            default:
            begin
                cur_val = 8'd0;
                stuffed = 1'b0;
            end
        endcase

        // a stuffed byte takes two steps: escape first, then the masked byte
        step_done = !(stuffed && needs_esc && !esc_pending_reg);
        if (stuffed && !step_done)
            emit_byte = ESC_BYTE;
        else if (stuffed)
            emit_byte = esc_pending_reg ? (cur_val ^ ESC_MASK) : cur_val;
        else
            emit_byte = FLAG_BYTE;

        if (can_emit)
        begin
            esc_pending_next = !step_done;
            if (step_done)
            begin
                unique case (state_reg)
                    ST_OPEN:  state_next = ST_DATA;
                    ST_DATA:
                    begin
                        if (last_reg)
                            state_next = ST_HI;
                        else
                            entry_done = 1'b1;
                    end
                    ST_HI:    state_next = ST_LO;
                    ST_LO:    state_next = ST_CLOSE;
                    ST_CLOSE: entry_done = 1'b1;
                    default:  state_next = ST_IDLE;
                endcase
            end
        end

        if ((state_reg == ST_IDLE) || entry_done)
        begin
            if (!q_empty)
            begin
                load       = 1'b1;
                byte_next  = q_head.data;
                last_next  = q_head.last;
                check_next = (check_mode == MODE_CRC) ? q_head.crc : fold_sum(q_head.sum);
                state_next = q_head.open ? ST_OPEN : ST_DATA;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    assign q_pop = load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_eof_next   = out_eof_reg;
        if (can_emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_byte;
            out_last_next  = entry_done;
            out_eof_next   = (state_reg == ST_CLOSE);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            esc_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            esc_pending_reg <= esc_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        check_reg    <= check_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_eof_reg  <= out_eof_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_eof_reg;

    `HFE_ASSERT_NOW(a_eof_is_flag, out_valid_reg && out_eof_reg,
        out_last_reg && (out_data_reg == FLAG_BYTE), "closing flag malformed")
    `HFE_ASSERT_NOW(a_esc_in_output, esc_pending_reg,
        out_valid_reg && (out_data_reg == ESC_BYTE) && !out_last_reg,
        "escape pending without escape word waiting")
    `HFE_ASSERT_NOW(a_esc_phase, esc_pending_reg,
        (state_reg == ST_DATA) || (state_reg == ST_HI) || (state_reg == ST_LO),
        "escape pending outside a stuffed phase")
    `HFE_ASSERT_NEXT(a_load_leaves_idle, load && q_head.open,
        state_reg == ST_OPEN, "new frame did not start with opening flag")

endmodule

>>> rtl/hdlc_frame_encoder_crc_core.sv
// top level of the hdlc framer with crc-16 or word-sum check
// usage:
//   s_* takes payload words of a frame, one byte each, s_tlast on the final byte.
//   m_* gives line words: opening flag, stuffed payload, stuffed check high
//   then low, closing flag. m_tlast ends the words caused by one input word,
//   m_tuser marks the closing flag.
//   the apb register check_mode (offset 0, reset 1) picks crc-16/xmodem (1) or
//   the inverted ones'-complement word sum (0); write it only while idle.
// path: an input taken into an idle block passes the queue, the sequencer state
//   and the output register before its first line word appears.
// throughput: the sequencer emits one line word per cycle unless m_tready holds the
//   output word, and an input occupies it for every line word it causes: 1 for a
//   plain byte, 2 when stuffed or when it opens a frame, up to 8 for a stuffed last
//   byte. the front end keeps the checks and feeds a two-entry queue, so input is
//   taken while the sequencer is busy until the queue is full.
// reset: frame closed, checks cleared, queue and output register empty,
//   check_mode back to crc.
// stall: with m_tready low the output word holds, the sequencer waits, and
//   s_tready drops once the queue fills.
module hdlc_frame_encoder_crc_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // data_byte
    input  logic                           s_tlast,   // last_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // out_byte
    output logic                           m_tlast,   // end_of_run
    output logic                           m_tuser,   // end_of_frame
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hfe_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import hfe_pkg::*;

    logic   check_mode_reg, check_mode_next;
    logic   q_full, q_empty, q_push, q_pop;
    entry_t q_entry, q_head;
    logic   reg_sel;

    // register index is the word address
    assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_CHECK_MODE);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {31'd0, check_mode_reg} : 32'd0;

    always_comb
    begin
        check_mode_next = check_mode_reg;
        if (psel && penable && pwrite && pready && reg_sel)
            check_mode_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            check_mode_reg <= MODE_CRC;
        else
            check_mode_reg <= check_mode_next;
    end

    hfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    hfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    hfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .check_mode (check_mode_reg),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

>>> sim/testbench.sv
// testbench of the hdlc framer: directed rows then random frames, checked against a predictor
module testbench;
    import hfe_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TOTAL_ITEMS = 130;

    localparam logic [CFG_ADDR_W-1:0] ADDR_CHECK_MODE = CFG_ADDR_W'(4 * REG_CHECK_MODE);
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED     = CFG_ADDR_W'(4);

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_WRITE,
        ROW_READ
    } row_kind_t;

    // typed line words sit first word in the low bits
    typedef struct {
        row_kind_t               kind;
        logic [7:0]              data;
        logic                    last;
        logic [CFG_ADDR_W-1:0]   addr;
        logic [31:0]             value;
        int                      n_typed;
        logic [63:0]             typed;
    } stim_row_t;

    typedef struct {
        logic [7:0] value;
        logic       eor;
        logic       eof;
    } line_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'd0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = 32'd0;
    logic [31:0]           prdata;
    logic                  pready;

    // typed expectation that travels with the word on s_tdata
    int                    item_typed_n = 0;
    logic [63:0]           item_typed = 64'd0;

    // predicted framer state
    logic                  fr_mode = MODE_CRC;
    logic                  fr_open = 1'b0;
    logic [15:0]           fr_crc = 16'd0;
    logic [31:0]           fr_sum = 32'd0;
    logic                  fr_odd = 1'b0;

    line_word_t            words_due[$];
    int                    inputs_sent = 0;
    int                    inputs_seen = 0;
    int                    errors = 0;
    int                    cycles = 0;
    int                    out_stall = 0;
    logic                  calm = 1'b0;

    hdlc_frame_encoder_crc_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int pick_wait();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
        errors++;
    endtask

    // crc-16/xmodem, one data bit per step
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic logic [15:0] sum_check(input logic [31:0] s);
        logic [31:0] t;
        t = {16'd0, s[31:16]} + {16'd0, s[15:0]};
        t = t + {16'd0, t[31:16]};
        return ~t[15:0];
    endfunction

    function automatic void push_word(input logic [7:0] v, input logic eof);
        line_word_t w;
        w.value = v;
        w.eor   = 1'b0;
        w.eof   = eof;
        words_due.push_back(w);
    endfunction

    function automatic void push_stuffed(input logic [7:0] v);
        if (v == FLAG_BYTE || v == ESC_BYTE)
        begin
            push_word(ESC_BYTE, 1'b0);
            push_word(v ^ ESC_MASK, 1'b0);
        end
        else
            push_word(v, 1'b0);
    endfunction

    // line words that one payload byte causes
    function automatic void frame_encode(input logic [7:0] b, input logic last,
                                         input int n_typed, input logic [63:0] typed);
        int          first;
        logic [15:0] chk;
        line_word_t  w;
        first = words_due.size();
        if (!fr_open)
        begin
            push_word(FLAG_BYTE, 1'b0);
            fr_open = 1'b1;
        end
        push_stuffed(b);
        fr_crc = crc_next(fr_crc, b);
        if (fr_odd)
        begin
            fr_sum = fr_sum + {24'd0, b};
            fr_odd = 1'b0;
        end
        else
        begin
            // a trailing odd byte goes in unshifted
            fr_sum = fr_sum + (last ? {24'd0, b} : {16'd0, b, 8'd0});
            fr_odd = 1'b1;
        end
        if (last)
        begin
            chk = (fr_mode == MODE_CRC) ? fr_crc : sum_check(fr_sum);
            push_stuffed(chk[15:8]);
            push_stuffed(chk[7:0]);
            push_word(FLAG_BYTE, 1'b1);
            fr_open = 1'b0;
            fr_crc  = 16'd0;
            fr_sum  = 32'd0;
            fr_odd  = 1'b0;
        end
        if (n_typed > 0)
        begin
            while (words_due.size() > first)
                void'(words_due.pop_back());
            for (int k = 0; k < n_typed; k++)
                push_word(typed[8*k +: 8], last && (k == n_typed - 1));
        end
        w = words_due.pop_back();
        w.eor = 1'b1;
        words_due.push_back(w);
    endfunction

    always @(posedge clk)
    begin
        line_word_t due;
        logic       ready_next;
        if (rst_n)
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == ADDR_CHECK_MODE)
                        fr_mode = pwdata[0];
                end
                else if (paddr == ADDR_CHECK_MODE && prdata !== {31'd0, fr_mode})
                    report_mismatch("check_mode readback", prdata, {31'd0, fr_mode});
            end
            if (s_tvalid && s_tready)
            begin
                frame_encode(s_tdata, s_tlast, item_typed_n, item_typed);
                inputs_seen++;
            end
            if (m_tvalid && m_tready)
            begin
                if (words_due.size() == 0)
                    report_mismatch("unexpected line word", {24'd0, m_tdata}, 32'd0);
                else
                begin
                    due = words_due.pop_front();
                    if (m_tdata !== due.value)
                        report_mismatch("out_byte", {24'd0, m_tdata}, {24'd0, due.value});
                    if (m_tlast !== due.eor)
                        report_mismatch("end_of_run", {31'd0, m_tlast}, {31'd0, due.eor});
                    if (m_tuser !== due.eof)
                        report_mismatch("end_of_frame", {31'd0, m_tuser}, {31'd0, due.eof});
                end
                out_stall = pick_wait();
            end
            if (out_stall > 0)
            begin
                ready_next = 1'b0;
                out_stall--;
            end
            else
                ready_next = 1'b1;
            m_tready <= ready_next;
        end
    end

    // lowers valid in the calling step, then waits until the line is quiet
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (words_due.size() != 0 || inputs_seen != inputs_sent);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last, input int n_typed,
                             input logic [63:0] typed);
        int gap;
        gap = pick_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid     <= 1'b1;
        s_tdata      <= b;
        s_tlast      <= last;
        item_typed_n <= n_typed;
        item_typed   <= typed;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        inputs_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [31:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        stim_row_t   rows[$];
        int          frame_len;
        int          switch_at;
        logic [7:0]  b;
        rows.push_back('{ROW_BYTE,  8'h00, 1'b1, ADDR_CHECK_MODE, 32'd0, 5, 64'h7E_0000_007E});
        rows.push_back('{ROW_READ,  8'h00, 1'b0, ADDR_CHECK_MODE, 32'd0, 0, 64'd0});
        rows.push_back('{ROW_BYTE,  8'h7E, 1'b0, ADDR_CHECK_MODE, 32'd0, 3, 64'h5E_7D7E});
        rows.push_back('{ROW_BYTE,  8'h7D, 1'b0, ADDR_CHECK_MODE, 32'd0, 2, 64'h5D7D});
        rows.push_back('{ROW_BYTE,  8'hFF, 1'b0, ADDR_CHECK_MODE, 32'd0, 1, 64'hFF});
        rows.push_back('{ROW_BYTE,  8'h00, 1'b0, ADDR_CHECK_MODE, 32'd0, 1, 64'h00});
        rows.push_back('{ROW_BYTE,  8'h5A, 1'b1, ADDR_CHECK_MODE, 32'd0, 0, 64'd0});
        // word sum, upper data bits set
        rows.push_back('{ROW_WRITE, 8'h00, 1'b0, ADDR_CHECK_MODE, 32'hFFFF_FFFE, 0, 64'd0});
        rows.push_back('{ROW_READ,  8'h00, 1'b0, ADDR_CHECK_MODE, 32'd0, 0, 64'd0});
        rows.push_back('{ROW_BYTE,  8'hFF, 1'b1, ADDR_CHECK_MODE, 32'd0, 5, 64'h7E_00FF_FF7E});
        // low check byte lands on the flag and gets stuffed
        rows.push_back('{ROW_BYTE,  8'h81, 1'b1, ADDR_CHECK_MODE, 32'd0, 6, 64'h7E5E_7DFF_817E});
        // all ones folds with carry to a zero check
        rows.push_back('{ROW_BYTE,  8'hFF, 1'b0, ADDR_CHECK_MODE, 32'd0, 2, 64'hFF7E});
        rows.push_back('{ROW_BYTE,  8'hFF, 1'b0, ADDR_CHECK_MODE, 32'd0, 1, 64'hFF});
        rows.push_back('{ROW_BYTE,  8'hFF, 1'b0, ADDR_CHECK_MODE, 32'd0, 1, 64'hFF});
        rows.push_back('{ROW_BYTE,  8'hFF, 1'b1, ADDR_CHECK_MODE, 32'd0, 4, 64'h7E00_00FF});
        // write past the register list is dropped
        rows.push_back('{ROW_WRITE, 8'h00, 1'b0, ADDR_UNUSED, 32'h0000_0001, 0, 64'd0});
        rows.push_back('{ROW_READ,  8'h00, 1'b0, ADDR_CHECK_MODE, 32'd0, 0, 64'd0});
        // mode switched in the middle of a frame
        rows.push_back('{ROW_BYTE,  8'h12, 1'b0, ADDR_CHECK_MODE, 32'd0, 0, 64'd0});
        rows.push_back('{ROW_BYTE,  8'h34, 1'b0, ADDR_CHECK_MODE, 32'd0, 0, 64'd0});
        rows.push_back('{ROW_WRITE, 8'h00, 1'b0, ADDR_CHECK_MODE, 32'h0000_0001, 0, 64'd0});
        rows.push_back('{ROW_BYTE,  8'h7E, 1'b1, ADDR_CHECK_MODE, 32'd0, 0, 64'd0});
        rows.push_back('{ROW_BYTE,  8'h7D, 1'b1, ADDR_CHECK_MODE, 32'd0, 0, 64'd0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            case (rows[i].kind)
                ROW_BYTE:  send_byte(rows[i].data, rows[i].last, rows[i].n_typed,
                                     rows[i].typed);
                ROW_WRITE: apb_access(1'b1, rows[i].addr, rows[i].value);
                default:   apb_access(1'b0, rows[i].addr, rows[i].value);
            endcase
        end

        while (inputs_sent < TOTAL_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                apb_access(1'b1, ADDR_CHECK_MODE, $urandom());
            else if ($urandom_range(0, 9) == 0)
                wait_drained();
            if ($urandom_range(0, 15) == 0)
                apb_access(1'b1, ADDR_UNUSED, $urandom());
            if ($urandom_range(0, 15) == 0)
                apb_access(1'b0, ADDR_CHECK_MODE, 32'd0);
            frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            switch_at = 0;
            if (frame_len > 1 && $urandom_range(0, 7) == 0)
                switch_at = $urandom_range(1, frame_len - 1);
            for (int k = 0; k < frame_len; k++)
            begin
                if (switch_at != 0 && k == switch_at)
                    apb_access(1'b1, ADDR_CHECK_MODE, $urandom());
                case ($urandom_range(0, 7))
                    0:       b = FLAG_BYTE;
                    1:       b = ESC_BYTE;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b, k == frame_len - 1, 0, 64'd0);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
